// ----- hw/rtl/fpfa_pkg.sv -----
// shared types and codes for the fixed partition fit allocator
package fpfa_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int POLICY_W   = 2;
   localparam int COUNT_W    = 5;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_ALLOC = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

   localparam logic CSR_IDX_POLICY = 1'b0;
   localparam logic CSR_IDX_COUNT  = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  part_index;
      logic [15:0] size_value;
      logic [7:0]  proc_id;
   } fpfa_req_type;

   typedef struct packed {
      logic       granted;
      logic [3:0] alloc_index;
      logic [7:0] proc_echo;
   } fpfa_rsp_type;

endpackage

// ----- hw/rtl/fixed_partition_fit_allocator.sv -----
// fixed partition allocator with first, best and worst fit over a scanned table
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  fpfa_req_type
//   rsp      out        rsp_valid / rsp_ready  fpfa_rsp_type
//   csr      in/out     psel, penable, pready  policy, partition count
//
// load, clear and unknown items give no result; the block stays idle and ready
// allocate scans the partition count, capped at NUM_PARTS, one table read and one compare a cycle,
// then the reply state registers the result; req_ready returns once the reply is sent
// first fit stops at the first hit, so it may finish sooner
// reset clears state, busy bits and registers; sizes and owners stay unknown
// a waiting result holds the reply cycle until rsp_ready; req is not taken meanwhile
module fixed_partition_fit_allocator
   import fpfa_pkg::*;
#(
   parameter int NUM_PARTS = 16,
   parameter int SIZE_BITS = 16,
   parameter int PROC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fpfa_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fpfa_rsp_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
   localparam int CNT_W = $clog2(NUM_PARTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPLY
   } state_type;

   state_type              state_ff, state_in;
   logic [POLICY_W-1:0]    policy_ff, policy_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [NUM_PARTS-1:0]   busy_ff, busy_in;
   logic [CNT_W-1:0]       limit_ff, limit_in;
   logic [CNT_W-1:0]       scan_idx_ff, scan_idx_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       chosen_ff, chosen_in;
   logic [SIZE_BITS-1:0]   chosen_size_ff, chosen_size_in;
   logic [SIZE_BITS-1:0]   need_ff, need_in;
   logic [PROC_BITS-1:0]   pid_ff, pid_in;
   logic [POLICY_W-1:0]    pol_ff, pol_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   fpfa_rsp_type           rsp_data_ff, rsp_data_in;

   logic [SIZE_BITS-1:0]   size_mem [NUM_PARTS];
   logic [PROC_BITS-1:0]   owner_mem [NUM_PARTS];
   logic [SIZE_BITS-1:0]   size_rd_ff;

   logic                   req_fire, csr_wr, load_ok, rd_en, owner_wr;
   logic                   fits, better;
   logic [IDX_W-1:0]       load_addr;
   logic [COUNT_W-1:0]     count_wdata;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign load_ok    = req_fire && (req_data.req_type == REQ_LOAD)
                       && (32'(req_data.part_index) < NUM_PARTS);
   assign load_addr  = IDX_W'(req_data.part_index);
   assign count_wdata = csr_pwdata[COUNT_W-1:0];

   // register file
   always_comb begin
      policy_in = policy_ff;
      count_in  = count_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            CSR_IDX_POLICY: policy_in = csr_pwdata[POLICY_W-1:0];
            CSR_IDX_COUNT:  count_in  = count_wdata;
            default:        ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_IDX_POLICY: csr_prdata = CSR_DATA_W'(policy_ff);
         CSR_IDX_COUNT:  csr_prdata = CSR_DATA_W'(count_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // compare unit
   assign fits = cmp_vld_ff && !busy_ff[cmp_idx_ff] && (size_rd_ff >= need_ff);
   always_comb begin
      case (pol_ff)
         POL_BEST:  better = !found_ff || (size_rd_ff < chosen_size_ff);
         POL_WORST: better = !found_ff || (size_rd_ff >= chosen_size_ff);
         default:   better = 1'b1;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      busy_in        = busy_ff;
      limit_in       = limit_ff;
      scan_idx_in    = scan_idx_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      found_in       = found_ff;
      chosen_in      = chosen_ff;
      chosen_size_in = chosen_size_ff;
      need_in        = need_ff;
      pid_in         = pid_ff;
      pol_in         = pol_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      rd_en          = 1'b0;
      owner_wr       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.req_type)
                  REQ_LOAD: begin
                     if (load_ok) begin
                        busy_in[load_addr] = 1'b0;
                     end
                  end
                  REQ_CLEAR: busy_in = '0;
                  REQ_ALLOC: begin
                     if (32'(count_ff) > NUM_PARTS) begin
                        limit_in = CNT_W'(NUM_PARTS);
                     end else begin
                        limit_in = CNT_W'(count_ff);
                     end
                     scan_idx_in = '0;
                     found_in    = 1'b0;
                     chosen_in   = '0;
                     need_in     = SIZE_BITS'(req_data.size_value);
                     pid_in      = PROC_BITS'(req_data.proc_id);
                     pol_in      = policy_ff;
                     state_in    = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (fits && better) begin
               found_in       = 1'b1;
               chosen_in      = cmp_idx_ff;
               chosen_size_in = size_rd_ff;
            end
            if (fits && pol_ff != POL_BEST && pol_ff != POL_WORST) begin
               state_in = ST_REPLY;
            end else if (scan_idx_ff == limit_ff) begin
               state_in = ST_REPLY;
            end else begin
               rd_en       = 1'b1;
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = scan_idx_ff[IDX_W-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.granted     = found_ff;
               rsp_data_in.alloc_index = found_ff ? 4'(chosen_ff) : 4'd0;
               rsp_data_in.proc_echo   = 8'(pid_ff);
               if (found_ff) begin
                  busy_in[chosen_ff] = 1'b1;
                  owner_wr           = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= '0;
         count_ff     <= '0;
         busy_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         cmp_vld_ff   <= cmp_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      limit_ff       <= limit_in;
      scan_idx_ff    <= scan_idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      chosen_ff      <= chosen_in;
      chosen_size_ff <= chosen_size_in;
      need_ff        <= need_in;
      pid_ff         <= pid_in;
      pol_ff         <= pol_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // size table
   always_ff @(posedge clock) begin
      if (load_ok) begin
         size_mem[load_addr] <= SIZE_BITS'(req_data.size_value);
      end
      if (rd_en) begin
         size_rd_ff <= size_mem[scan_idx_ff[IDX_W-1:0]];
      end
   end

   // owner table
   always_ff @(posedge clock) begin
      if (owner_wr) begin
         owner_mem[chosen_ff] <= pid_ff;
      end
   end

endmodule

// ----- hw/rtl/fpfa_checker.sv -----
// port checks for the fixed partition fit allocator
module fpfa_checker
   import fpfa_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input fpfa_req_type req_data,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input fpfa_rsp_type rsp_data,
   input logic         csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item dropped or changed while stalled");

   a_no_grant_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.granted |-> rsp_data.alloc_index == 4'd0)
      else $error("refused item carries a nonzero index");

   a_alloc_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.req_type == REQ_ALLOC |=> !req_ready)
      else $error("ready while an allocate item is being scanned");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("block not quiet after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port stalled");

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_data   (req_data),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);

// ----- sim/fixed_partition_fit_allocator_test.sv -----
// self-checking testbench for the fixed partition fit allocator
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_test;
   import fpfa_pkg::*;

   localparam int NUM_PARTS     = 16;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RAND_PHASES   = 12;
   localparam int PHASE_ITEMS   = 112;

   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   localparam int IDLE_NONE     = 0;
   localparam int IDLE_SENDER   = 1;
   localparam int IDLE_RECEIVER = 2;
   localparam int IDLE_BOTH     = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   fpfa_req_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   fpfa_rsp_type          rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   fixed_partition_fit_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mirror of the allocator state and registers
   logic [POLICY_W-1:0] cfg_policy = POL_FIRST;
   logic [COUNT_W-1:0]  cfg_count  = '0;
   logic [15:0]         part_size [NUM_PARTS];
   logic                part_busy [NUM_PARTS];
   logic [7:0]          part_owner [NUM_PARTS];

   fpfa_req_type pending_q [$];
   fpfa_rsp_type grant_q [$];
   fpfa_rsp_type next_grant;

   logic req_fire = 1'b0;
   int   send_gap_pct = 0;
   int   stall_pct = 0;
   int   items_queued = 0;
   int   items_accepted = 0;
   int   fail_count = 0;
   int   grants_seen = 0;
   int   refusals_seen = 0;
   int   idle_cycles = 0;

   task automatic predict_grant(input fpfa_req_type item);
      int          limit;
      logic        found;
      int          chosen;
      logic [15:0] chosen_size;
      fpfa_rsp_type reply;
      limit = (cfg_count > NUM_PARTS) ? NUM_PARTS : int'(cfg_count);
      found = 1'b0;
      chosen = 0;
      chosen_size = '0;
      case (item.req_type)
         REQ_LOAD: begin
            part_size[item.part_index] = item.size_value;
            part_busy[item.part_index] = 1'b0;
         end
         REQ_CLEAR: begin
            for (int j = 0; j < NUM_PARTS; j++) part_busy[j] = 1'b0;
         end
         REQ_ALLOC: begin
            for (int j = 0; j < limit; j++) begin
               if (!part_busy[j] && part_size[j] >= item.size_value) begin
                  if (cfg_policy == POL_BEST) begin
                     if (!found || part_size[j] < chosen_size) begin
                        found = 1'b1;
                        chosen = j;
                        chosen_size = part_size[j];
                     end
                  end else if (cfg_policy == POL_WORST) begin
                     if (!found || part_size[j] >= chosen_size) begin
                        found = 1'b1;
                        chosen = j;
                        chosen_size = part_size[j];
                     end
                  end else if (!found) begin
                     found = 1'b1;
                     chosen = j;
                  end
               end
            end
            if (found) begin
               part_busy[chosen] = 1'b1;
               part_owner[chosen] = item.proc_id;
            end
            reply.granted = found;
            reply.alloc_index = found ? 4'(chosen) : 4'd0;
            reply.proc_echo = item.proc_id;
            grant_q.push_back(reply);
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_fire) begin
            if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               req_data <= pending_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predict_grant(req_data);
            items_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (grant_q.size() == 0) begin
               $display("%0t: result with no request waiting, actual %p", $time, rsp_data);
               fail_count++;
            end else begin
               next_grant = grant_q.pop_front();
               check_field("granted", next_grant.granted, rsp_data.granted);
               check_field("alloc_index", next_grant.alloc_index, rsp_data.alloc_index);
               check_field("proc_echo", next_grant.proc_echo, rsp_data.proc_echo);
               if (rsp_data.granted) grants_seen++;
               else refusals_seen++;
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(negedge clock);
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("** fixed_partition_fit_allocator: FAILED **");
      $finish;
   end

   task automatic write_csr(input int idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(idx << 2);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == CSR_IDX_POLICY) cfg_policy = value[POLICY_W-1:0];
      else if (idx == CSR_IDX_COUNT) cfg_count = value[COUNT_W-1:0];
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] policy_word,
                             input logic [CSR_DATA_W-1:0] count_word);
      write_csr(CSR_IDX_POLICY, policy_word);
      write_csr(CSR_IDX_COUNT, count_word);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         IDLE_SENDER:   begin send_gap_pct = 58; stall_pct = 0;  end
         IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct = 58; end
         IDLE_BOTH:     begin send_gap_pct = 27; stall_pct = 27; end
         default:       begin send_gap_pct = 0;  stall_pct = 0;  end
      endcase
   endtask

   task automatic push_item(input logic [1:0] kind, input logic [3:0] idx,
                            input logic [15:0] size, input logic [7:0] pid);
      fpfa_req_type item;
      item.req_type = kind;
      item.part_index = idx;
      item.size_value = size;
      item.proc_id = pid;
      pending_q.push_back(item);
      items_queued++;
   endtask

   task automatic drain();
      while (items_accepted != items_queued || grant_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_size();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) return 16'($urandom_range(0, 24));
      if (roll < 8) return 16'($urandom());
      if (roll == 8) return 16'd0;
      return 16'hFFFF;
   endfunction

   task automatic push_random_item();
      int unsigned roll;
      logic [1:0]  kind;
      roll = $urandom_range(0, 99);
      if (roll < 60) kind = REQ_ALLOC;
      else if (roll < 82) kind = REQ_LOAD;
      else if (roll < 92) kind = REQ_CLEAR;
      else kind = REQ_UNKNOWN;
      push_item(kind, 4'($urandom()), pick_size(), 8'($urandom()));
   endtask

   logic [15:0] seed_sizes [NUM_PARTS] = '{
      16'd0, 16'hFFFF, 16'd100, 16'd50, 16'd100, 16'hFFFF, 16'd50, 16'd1,
      16'd7, 16'd3000, 16'd50, 16'd2, 16'd40000, 16'd100, 16'd9, 16'd50
   };

   initial begin
      logic [COUNT_W-1:0] count_pick;
      for (int j = 0; j < NUM_PARTS; j++) begin
         part_busy[j] = 1'b0;
         part_size[j] = '0;
         part_owner[j] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_idling(IDLE_NONE);

      // empty table, then every partition loaded before any scan reaches it
      set_config(POL_FIRST, 0);
      push_item(REQ_ALLOC, 4'd0, 16'd0, 8'hA5);
      drain();
      for (int j = 0; j < NUM_PARTS; j++) push_item(REQ_LOAD, 4'(j), seed_sizes[j], 8'($urandom()));
      push_item(REQ_UNKNOWN, 4'hF, 16'hFFFF, 8'hFF);
      drain();

      set_config(POL_BEST, NUM_PARTS);
      push_item(REQ_ALLOC, 4'd0, 16'd50, 8'h01);
      push_item(REQ_ALLOC, 4'd0, 16'd50, 8'h02);
      push_item(REQ_ALLOC, 4'hF, 16'd0, 8'h00);
      drain();

      set_config(POL_WORST, NUM_PARTS);
      push_item(REQ_ALLOC, 4'd0, 16'd1, 8'h80);
      push_item(REQ_ALLOC, 4'd0, 16'hFFFF, 8'hFF);
      push_item(REQ_CLEAR, 4'hA, 16'h5555, 8'h55);
      drain();

      // unknown policy and an oversized count, upper bits set
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_item(REQ_ALLOC, 4'd0, 16'd100, 8'h3C);
      push_item(REQ_ALLOC, 4'd0, 16'd2, 8'hC3);
      drain();

      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         if (phase % 3 == 0) count_pick = COUNT_W'(NUM_PARTS);
         else count_pick = COUNT_W'($urandom_range(0, 31));
         set_config(($urandom() << POLICY_W) | ((phase + phase / 4) % 4),
                    ($urandom() << COUNT_W) | count_pick);
         set_idling(phase % 4);
         for (int n = 0; n < PHASE_ITEMS; n++) push_random_item();
         drain();
      end

      $display("run covered %0d request items over %0d register settings and four idling modes",
               items_accepted, RAND_PHASES + 4);
      $display("%0d allocations granted and %0d refused", grants_seen, refusals_seen);
      if (fail_count == 0 && grant_q.size() == 0) begin
         $display("** fixed_partition_fit_allocator: PASSED **");
      end else begin
         $display("** fixed_partition_fit_allocator: FAILED **");
      end
      $finish;
   end

endmodule
